// ===== sv/msub_pkg.sv =====
// shared types and constants for the subset sum block
package msub_pkg;

   localparam int BUDGET_MAX = 1023;
   localparam int ROW_DEPTH  = BUDGET_MAX + 1;
   localparam int ROW_AW     = $clog2(ROW_DEPTH);
   localparam int FIELD_W    = 10;

   typedef logic [ROW_AW-1:0]  row_addr_type;
   typedef logic [FIELD_W-1:0] field_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_ANSWER
   } msub_state_type;

   typedef struct packed {
      logic         wr_en;
      logic         wr_zero;
      row_addr_type wr_addr;
      row_addr_type rd_a_addr;
      row_addr_type rd_b_addr;
   } row_ctl_type;

endpackage

// ===== sv/max_subset_sum_under_budget_top.sv =====
// top level of the subset sum under budget block
//
// prices come in on the req_ channel, one transfer per item, req_last_item
// marking the final item of a set. the csr_ channel writes the budget and
// is always ready; write it only while the block is idle.
// each item with a price p from 1 to 1023 walks the best-sum row from the
// top entry down to entry p through one shared add and compare unit fed by
// a two-read, one-write row memory.
// a price of zero is taken without a walk; a price above the budget still
// walks the row.
// after the last item the entry at the budget is read and moved to the
// rsp_ output register, then a clearing sweep zeroes the row; req_stall
// stays high throughout.
// the result sits in its register until the receiver drops rsp_stall; the
// sweep runs meanwhile, and a further answer waits only if the earlier one
// has not yet been taken.
// reset clears the budget to zero and starts the same clearing sweep
// before the first price is taken.
module max_subset_sum_under_budget_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  msub_pkg::field_type req_price,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output msub_pkg::field_type rsp_best_total,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  msub_pkg::field_type csr_budget
);
   import msub_pkg::*;

   row_ctl_type  row_ctl;
   row_addr_type row_price;
   row_addr_type rd_a_data;

   assign csr_ready = 1'b1;

   msub_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_price      (req_price),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_total (rsp_best_total),
      .csr_valid      (csr_valid),
      .csr_budget     (csr_budget),
      .row_ctl        (row_ctl),
      .row_price      (row_price),
      .rd_a_data      (rd_a_data)
   );

   msub_row u_row (
      .clock     (clock),
      .ctl       (row_ctl),
      .price     (row_price),
      .rd_a_data (rd_a_data)
   );

endmodule

// ===== sv/msub_row.sv =====
// best-sum row memory with the shared add and compare unit
module msub_row (
   input  logic                  clock,
   input  msub_pkg::row_ctl_type ctl,
   input  msub_pkg::row_addr_type price,
   output msub_pkg::row_addr_type rd_a_data
);
   import msub_pkg::*;

   row_addr_type      best_row_ff [ROW_DEPTH];
   row_addr_type      rd_a_ff;
   row_addr_type      rd_b_ff;
   logic [ROW_AW:0]   cand;
   row_addr_type      best_in;

   // candidate is price plus entry at b - price, kept if larger
   always_comb begin
      cand = {1'b0, price} + {1'b0, rd_b_ff};
      if (ctl.wr_zero) begin
         best_in = '0;
      end else if ({1'b0, rd_a_ff} < cand) begin
         best_in = cand[ROW_AW-1:0];
      end else begin
         best_in = rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         best_row_ff[ctl.wr_addr] <= best_in;
      end
      rd_a_ff <= best_row_ff[ctl.rd_a_addr];
      rd_b_ff <= best_row_ff[ctl.rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;

endmodule

// ===== sv/msub_ctrl.sv =====
// sequencer for row scan, answer read-out and clearing sweep
module msub_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  msub_pkg::field_type    req_price,
   input  logic                   req_last_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output msub_pkg::field_type    rsp_best_total,
   input  logic                   csr_valid,
   input  msub_pkg::field_type    csr_budget,
   output msub_pkg::row_ctl_type  row_ctl,
   output msub_pkg::row_addr_type row_price,
   input  msub_pkg::row_addr_type rd_a_data
);
   import msub_pkg::*;

   msub_state_type state_ff, state_in;
   row_addr_type   b_ff, b_in;
   row_addr_type   p_ff;
   logic           last_ff;
   logic           pend_ff;
   row_addr_type   pend_addr_ff;
   field_type      budget_ff;
   logic           rsp_valid_ff;
   field_type      rsp_total_ff;
   row_addr_type   eff;
   logic           req_acc;
   logic           p_fit;
   logic           rsp_free;

   assign req_acc  = req_valid && (state_ff == ST_IDLE);
   assign p_fit    = (req_price != '0) && (32'(req_price) <= 32'(BUDGET_MAX));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign eff      = (32'(budget_ff) > 32'(BUDGET_MAX)) ? ROW_AW'(BUDGET_MAX)
                                                        : ROW_AW'(budget_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (b_ff == '0) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (p_fit) begin
                  state_in = ST_SCAN;
               end else if (req_last_item) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SCAN: begin
            if (b_ff == p_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = last_ff ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            state_in = ST_ANSWER;
         end
         ST_ANSWER: begin
            if (rsp_free) state_in = ST_CLEAR;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall         = 1'b1;
      row_ctl.wr_en     = pend_ff;
      row_ctl.wr_zero   = 1'b0;
      row_ctl.wr_addr   = pend_addr_ff;
      row_ctl.rd_a_addr = b_ff;
      row_ctl.rd_b_addr = b_ff - p_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            row_ctl.wr_en   = 1'b1;
            row_ctl.wr_zero = 1'b1;
            row_ctl.wr_addr = b_ff;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SCAN, ST_DRAIN: begin
         end
         ST_FETCH, ST_ANSWER: begin
            row_ctl.rd_a_addr = eff;
         end
         default: begin
         end
      endcase
   end

   // scan and sweep counter
   always_comb begin
      b_in = b_ff;
      unique case (state_ff)
         ST_CLEAR, ST_SCAN: begin
            b_in = b_ff - 1'b1;
         end
         ST_IDLE, ST_ANSWER: begin
            b_in = ROW_AW'(BUDGET_MAX);
         end
         ST_DRAIN, ST_FETCH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         b_ff         <= ROW_AW'(BUDGET_MAX);
         last_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         budget_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         b_ff     <= b_in;
         pend_ff  <= (state_ff == ST_SCAN);
         if (req_acc) begin
            last_ff <= req_last_item;
         end
         if (csr_valid) begin
            budget_ff <= csr_budget;
         end
         if (state_ff == ST_ANSWER && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= b_ff;
      if (req_acc) begin
         p_ff <= ROW_AW'(req_price);
      end
      if (state_ff == ST_ANSWER && rsp_free) begin
         rsp_total_ff <= FIELD_W'(rd_a_data);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_total = rsp_total_ff;
   assign row_price      = p_ff;

endmodule

// ===== sv/msub_chk.sv =====
// port-level checks for the subset sum block and their bind
module msub_chk (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_last_item,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input msub_pkg::field_type rsp_best_total
);

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_total))
      else $error("result changed while stalled");

   // clearing sweep after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input taken during clearing sweep");

   // last item of a set makes the block busy
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_item |=> req_stall)
      else $error("block ready right after last item");

   // an answer appears only while the row is being cleared
   a_answer_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("answer issued while idle");

endmodule

bind max_subset_sum_under_budget_top msub_chk u_chk (.*);

// ===== verif/tb.sv =====
// testbench for the subset sum block: directed and random price sets checked against a row model
`timescale 1ns / 1ps

module tb;
   import msub_pkg::*;

   localparam int TOTAL_ITEMS   = 580;
   localparam int SETTLE_CYCLES = 1100;
   localparam int LONG_HOLD     = 5000;

   typedef struct packed {
      field_type price;
      logic      last_item;
   } priced_item_type;

   logic      clock;
   logic      reset         = 1'b1;
   logic      req_valid     = 1'b0;
   logic      req_stall;
   field_type req_price     = '0;
   logic      req_last_item = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall     = 1'b0;
   field_type rsp_best_total;
   logic      csr_valid     = 1'b0;
   logic      csr_ready;
   field_type csr_budget    = '0;

   priced_item_type price_q[$];
   field_type       best_total_q[$];
   field_type       sum_row [0:BUDGET_MAX];
   field_type       budget_now     = '0;
   priced_item_type next_item;
   logic            req_took       = 1'b0;
   int              gap_left       = 0;
   int              stall_left     = 0;
   bit              send_calm      = 1'b0;
   bit              rsp_calm       = 1'b0;
   bit              hold_request   = 1'b0;
   int              mismatch_count = 0;
   int              items_queued   = 0;

   max_subset_sum_under_budget_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_price      (req_price),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_best_total (rsp_best_total),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_budget     (csr_budget)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_row();
      for (int b = 0; b <= BUDGET_MAX; b++) sum_row[b] = '0;
   endfunction

   // top-down walk so each price is used at most once per set
   function automatic void add_price_to_row(input field_type price);
      logic [FIELD_W:0] with_item;
      if (price == 0) return;
      for (int b = BUDGET_MAX; b >= int'(price); b--) begin
         with_item = price + sum_row[b - price];
         if (with_item > sum_row[b]) sum_row[b] = with_item[FIELD_W-1:0];
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // sender
   always @(negedge clock) begin
      if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      if (!(req_valid && !req_took)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (price_q.size() != 0) begin
            next_item = price_q.pop_front();
            req_valid     <= 1'b1;
            req_price     <= next_item.price;
            req_last_item <= next_item.last_item;
            if (send_calm) begin
               gap_left = 0;
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: gap_left = 0;
                  5, 6, 7, 8:    gap_left = $urandom_range(1, 3);
                  default:       gap_left = $urandom_range(10, 60);
               endcase
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if ($urandom_range(0, 499) == 0) rsp_calm = !rsp_calm;
      if (hold_request) begin
         hold_request = 1'b0;
         stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_calm) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5: stall_left = $urandom_range(1, 4);
               6:                stall_left = $urandom_range(20, 200);
               default: ;
            endcase
         end
      end
   end

   // input transfers feed the row model, output transfers are checked
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
         clear_row();
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            add_price_to_row(req_price);
            if (req_last_item) begin
               best_total_q.push_back(sum_row[budget_now]);
               clear_row();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (best_total_q.size() == 0) begin
               report_mismatch($sformatf("best_total %0d with no answer pending",
                                         rsp_best_total));
            end else if (rsp_best_total !== best_total_q[0]) begin
               report_mismatch($sformatf("best_total got %0d expected %0d",
                                         rsp_best_total, best_total_q[0]));
               void'(best_total_q.pop_front());
            end else begin
               void'(best_total_q.pop_front());
            end
         end
      end
   end

   task automatic queue_item(input field_type price, input logic last_item);
      price_q.push_back('{price: price, last_item: last_item});
      items_queued++;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (price_q.size() != 0 || (req_valid && !req_took) || best_total_q.size() != 0);
   endtask

   task automatic write_budget(input field_type value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid  <= 1'b1;
      csr_budget <= value;
      do @(posedge clock); while (!csr_ready);
      budget_now = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      #1;
   endtask

   initial begin
      field_type b;
      field_type price;
      int        set_len;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      #1;

      write_budget(10'd1023);
      queue_item(10'd1023, 1'b1);
      queue_item(10'd0, 1'b0);
      queue_item(10'd0, 1'b1);
      queue_item(10'd1, 1'b0);
      queue_item(10'd1022, 1'b0);
      queue_item(10'd512, 1'b1);

      write_budget(10'd0);
      queue_item(10'd5, 1'b0);
      queue_item(10'd0, 1'b1);
      queue_item(10'd1, 1'b1);

      write_budget(10'd100);
      queue_item(10'd101, 1'b1);
      queue_item(10'd100, 1'b1);
      queue_item(10'd60, 1'b0);
      queue_item(10'd50, 1'b0);
      queue_item(10'd45, 1'b1);

      // budget raised part way through a set
      queue_item(10'd300, 1'b0);
      queue_item(10'd700, 1'b0);
      write_budget(10'd1000);
      queue_item(10'd200, 1'b1);

      // receiver holds off while quick sets keep coming
      wait_drained();
      hold_request = 1'b1;
      for (int i = 0; i < 5; i++) queue_item(field_type'(1000 - i), 1'b1);
      wait_drained();

      while (items_queued < TOTAL_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
               0:       b = '0;
               1:       b = '1;
               2:       b = field_type'($urandom_range(1, 63));
               default: b = field_type'($urandom_range(64, 1023));
            endcase
            write_budget(b);
         end else if ($urandom_range(0, 5) == 0) begin
            wait_drained();
         end
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         for (int i = 0; i < set_len; i++) begin
            b = budget_now;
            case ($urandom_range(0, 11))
               0:       price = '0;
               1:       price = '1;
               2:       price = (b < 1023) ? field_type'($urandom_range(b + 1, 1023)) : '1;
               3:       price = field_type'($urandom_range(0, 1023));
               4, 5, 6: price = field_type'($urandom_range(1, b / 3 + 1));
               default: price = field_type'($urandom_range(1, (b > 1) ? b : 1));
            endcase
            queue_item(price, i == set_len - 1);
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && best_total_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
